@@ src/rv32_pkg.sv @@
// shared types, constants and decode helpers for the rv32i execute block
package rv32_pkg;
	localparam int DMEM_WORDS = 16384;
	localparam int DMEM_AW = $clog2(DMEM_WORDS);
	localparam logic [31:0] START_PC_RST = 32'h0000_1000;

	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_AUIPC  = 7'h17;
	localparam logic [6:0] OP_JAL    = 7'h6f;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_REG    = 7'h33;
	localparam logic [6:0] OP_FENCE  = 7'h0f;
	localparam logic [6:0] OP_SYSTEM = 7'h73;

	localparam logic [31:0] INST_ECALL  = 32'h0000_0073;
	localparam logic [31:0] INST_EBREAK = 32'h0010_0073;
	localparam logic [6:0] F7_ZERO = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BAD    = 2'd1;
	localparam logic [1:0] ST_HALT   = 2'd2;
	localparam logic [1:0] ST_HALTED = 2'd3;

	typedef struct packed {
		logic [31:0] instruction_pc;
		logic [31:0] next_pc;
		logic        reg_write;
		logic [4:0]  reg_index;
		logic [31:0] reg_value;
		logic [1:0]  status;
	} result_t;

	function automatic logic [31:0] sext12(input logic [11:0] v);
		sext12 = {{20{v[11]}}, v};
	endfunction
endpackage

@@ src/rv32_word_if.sv @@
// valid/ready channel carrying one word of a given width
interface rv32_word_if #(parameter int W = 32);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/rv32_ram.sv @@
// generic single-port ram with registered read
module rv32_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

@@ src/rv32_front.sv @@
// instruction word queue between the input channel and the execute engine
module rv32_front import rv32_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	rv32_word_if.sink   instr,
	input  logic        take,
	output logic        avail,
	output logic [31:0] head
);
	logic [31:0] buf_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	logic        push;

	assign instr.ready = (cnt_q != 2'd2);
	assign push = instr.valid && instr.ready;
	assign avail = (cnt_q != 2'd0);
	assign head = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= instr.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, take};
		end
	end
endmodule

@@ src/rv32_back.sv @@
// execute engine: register read, alu, memory access, writeback and result register
module rv32_back import rv32_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_data,
	input  logic        avail,
	input  logic [31:0] head,
	output logic        take,
	rv32_word_if.source res
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;

	logic [1:0]  state_q;
	logic [31:0] pc_q;
	logic        halted_q;
	logic [31:0] inst_s1;
	logic [31:0] rf_q [32];
	logic        out_v_q;
	result_t     out_q;
	logic               clr_q;
	logic [DMEM_AW-1:0] clr_addr_q;

	logic [31:0] rs1v, rs2v, mrd, mwd, addr, imm_i, imm_s, imm_b, imm_j, sum_ls;
	logic [6:0]  opc, f7;
	logic [2:0]  f3;
	logic [4:0]  rd, sh;
	logic        bad, wr, take_br, ebreak, is_store, fire;
	logic [31:0] val, nxt, w, aluv, b;
	logic [4:0]  bsh, hsh;
	result_t     r;

	assign opc = inst_s1[6:0];
	assign rd  = inst_s1[11:7];
	assign f3  = inst_s1[14:12];
	assign f7  = inst_s1[31:25];
	assign imm_i = sext12(inst_s1[31:20]);
	assign imm_s = sext12({inst_s1[31:25], inst_s1[11:7]});
	assign imm_b = {{20{inst_s1[31]}}, inst_s1[7], inst_s1[30:25], inst_s1[11:8], 1'b0};
	assign imm_j = {{12{inst_s1[31]}}, inst_s1[19:12], inst_s1[20], inst_s1[30:21], 1'b0};
	assign rs1v = (inst_s1[19:15] == 5'd0) ? 32'd0 : rf_q[inst_s1[19:15]];
	assign rs2v = (inst_s1[24:20] == 5'd0) ? 32'd0 : rf_q[inst_s1[24:20]];
	assign sum_ls = rs1v + ((opc == OP_STORE) ? imm_s : imm_i);

	// address from the incoming word for the registered memory read
	logic [31:0] hi_i, rs1_h, addr_h;
	logic [4:0]  hr1;
	assign hr1 = head[19:15];
	assign rs1_h = (hr1 == 5'd0) ? 32'd0 : rf_q[hr1];
	assign hi_i = (head[6:0] == OP_STORE) ? sext12({head[31:25], head[11:7]})
		: sext12(head[31:20]);
	assign addr_h = rs1_h + hi_i;
	assign addr = sum_ls;
	assign bsh = {addr[1:0], 3'b000};
	assign hsh = {addr[1], 4'b0000};

	assign take = (state_q == S_IDLE) && avail && !cfg_we && !clr_q;
	assign fire = (state_q == S_EXEC) && (!out_v_q || res.ready);

	// clearing pass after reset writes zero to every memory word
	rv32_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
		.clk(clk),
		.we(clr_q || (fire && is_store && !halted_q)),
		.addr(clr_q ? clr_addr_q : (take ? addr_h[DMEM_AW+1:2] : addr[DMEM_AW+1:2])),
		.wdata(clr_q ? 32'd0 : mwd),
		.rdata(mrd)
	);

	always_comb begin
		b = (opc == OP_REG) ? rs2v : imm_i;
		sh = (opc == OP_REG) ? rs2v[4:0] : inst_s1[24:20];
		case (f3)
			3'd0: aluv = (opc == OP_REG && f7 == F7_ALT) ? rs1v - b : rs1v + b;
			3'd1: aluv = rs1v << sh;
			3'd2: aluv = {31'd0, $signed(rs1v) < $signed(b)};
			3'd3: aluv = {31'd0, rs1v < b};
			3'd4: aluv = rs1v ^ b;
			3'd5: aluv = (f7 == F7_ALT) ? $unsigned($signed(rs1v) >>> sh) : rs1v >> sh;
			3'd6: aluv = rs1v | b;
			default: aluv = rs1v & b;
		endcase
	end

	always_comb begin
		bad = 1'b0; wr = 1'b0; val = 32'd0; nxt = pc_q + 32'd4;
		take_br = 1'b0; ebreak = 1'b0; is_store = 1'b0; mwd = mrd; w = mrd;
		case (opc)
			OP_LUI: begin val = {inst_s1[31:12], 12'd0}; wr = 1'b1; end
			OP_AUIPC: begin val = pc_q + {inst_s1[31:12], 12'd0}; wr = 1'b1; end
			OP_JAL: begin val = pc_q + 32'd4; wr = 1'b1; nxt = pc_q + imm_j; end
			OP_JALR: begin
				if (f3 != 3'd0) bad = 1'b1;
				else begin
					val = pc_q + 32'd4; wr = 1'b1;
					nxt = (rs1v + imm_i) & 32'hffff_fffe;
				end
			end
			OP_BRANCH: begin
				case (f3)
					3'd0: take_br = rs1v == rs2v;
					3'd1: take_br = rs1v != rs2v;
					3'd4: take_br = $signed(rs1v) < $signed(rs2v);
					3'd5: take_br = !($signed(rs1v) < $signed(rs2v));
					3'd6: take_br = rs1v < rs2v;
					3'd7: take_br = rs1v >= rs2v;
					default: bad = 1'b1;
				endcase
				if (take_br) nxt = pc_q + imm_b;
			end
			OP_LOAD: begin
				w = mrd >> bsh;
				wr = 1'b1;
				case (f3)
					3'd0: val = {{24{w[7]}}, w[7:0]};
					3'd1: begin w = mrd >> hsh; val = {{16{w[15]}}, w[15:0]}; end
					3'd2: val = mrd;
					3'd4: val = {24'd0, w[7:0]};
					3'd5: begin w = mrd >> hsh; val = {16'd0, w[15:0]}; end
					default: begin bad = 1'b1; wr = 1'b0; end
				endcase
			end
			OP_STORE: begin
				is_store = 1'b1;
				case (f3)
					3'd0: mwd = (mrd & ~(32'hff << bsh)) | ({24'd0, rs2v[7:0]} << bsh);
					3'd1: mwd = (mrd & ~(32'hffff << hsh)) | ({16'd0, rs2v[15:0]} << hsh);
					3'd2: mwd = rs2v;
					default: begin bad = 1'b1; is_store = 1'b0; end
				endcase
			end
			OP_IMM: begin
				if (f3 == 3'd1 && f7 != F7_ZERO) bad = 1'b1;
				else if (f3 == 3'd5 && f7 != F7_ZERO && f7 != F7_ALT) bad = 1'b1;
				else begin val = aluv; wr = 1'b1; end
			end
			OP_REG: begin
				if (f7 == F7_ZERO || (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
					val = aluv; wr = 1'b1;
				end else bad = 1'b1;
			end
			OP_FENCE: ;
			OP_SYSTEM: begin
				if (inst_s1 == INST_EBREAK) ebreak = 1'b1;
				else if (inst_s1 != INST_ECALL) bad = 1'b1;
			end
			default: bad = 1'b1;
		endcase
		if (bad) begin wr = 1'b0; val = 32'd0; nxt = pc_q + 32'd4; end
		r.instruction_pc = pc_q;
		r.next_pc = nxt;
		r.status = bad ? ST_BAD : (ebreak ? ST_HALT : ST_OK);
		if (wr && rd != 5'd0) begin
			r.reg_write = 1'b1; r.reg_index = rd; r.reg_value = val;
		end else begin
			r.reg_write = 1'b0; r.reg_index = 5'd0; r.reg_value = 32'd0;
		end
		if (halted_q) begin
			r.next_pc = pc_q; r.status = ST_HALTED;
			r.reg_write = 1'b0; r.reg_index = 5'd0; r.reg_value = 32'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) inst_s1 <= head;
		if (fire) out_q <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= START_PC_RST;
			halted_q <= 1'b0;
			out_v_q <= 1'b0;
			clr_q <= 1'b1;
			clr_addr_q <= '0;
			for (int i = 0; i < 32; i++) rf_q[i] <= 32'd0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + DMEM_AW'(1);
				if (clr_addr_q == DMEM_AW'(DMEM_WORDS - 1)) clr_q <= 1'b0;
			end
			if (fire) out_v_q <= 1'b1;
			else if (res.ready) out_v_q <= 1'b0;
			if (cfg_we) begin
				pc_q <= cfg_data;
				halted_q <= 1'b0;
			end else if (fire) begin
				pc_q <= r.next_pc;
				if (ebreak && !bad && !halted_q) halted_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: if (take) state_q <= S_EXEC;
				S_EXEC: begin
					if (fire) begin
						state_q <= S_IDLE;
						if (r.reg_write) rf_q[r.reg_index] <= r.reg_value;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid = out_v_q;
	assign res.data = out_q;
endmodule

@@ src/rv32i_instruction_execute.sv @@
// top level of the rv32i execute block
//  channel      dir  word
//  instr        in   32-bit instruction
//  res          out  pc, next pc, register write, status
//  start_pc     in   write enable + 32-bit data
// per instruction: register read and data memory read when the word is taken,
// then execute, writeback and memory write once the result register is free.
// a two-entry queue holds words while the engine or result register stalls.
// reset: pc 0x1000, registers zero, not halted; a pass then clears all 16384 words of
// the data memory, and no word is taken from the queue until it ends.
module rv32i_instruction_execute import rv32_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start_pc_we,
	input  logic [31:0] start_pc_data,
	rv32_word_if.sink   instr,
	rv32_word_if.source res
);
	logic        take, avail;
	logic [31:0] head;

	rv32_front u_front (
		.clk(clk), .arst_n(arst_n), .instr(instr),
		.take(take), .avail(avail), .head(head)
	);

	rv32_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(start_pc_we), .cfg_data(start_pc_data),
		.avail(avail), .head(head), .take(take), .res(res)
	);
endmodule
